// ===== src/tpbb_pkg.sv =====
// Package: shared types, widths and constants of the transformed-point bounding box.
package tpbb_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int SUM_W = 66;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_MATRIX = 2'd1,
        KIND_VERTEX = 2'd2,
        KIND_RSVD   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         entry_index;
        logic signed [31:0] matrix_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } state_t;

endpackage

// ===== src/transformed_point_bounding_box_core.sv =====
// The back end takes one item at a time and takes no new item until its result is accepted;
// for vertex beats the pace is set by the restoring divider that produces one quotient bit
// per cycle for each of the three axes after 12 multiplies.
// A two-entry queue takes input beats while the back end works or a result waits.
// Synchronous active-low reset restores the identity matrix and an empty box.
// Top level: stream ports, front-end queue and back-end datapath.
module transformed_point_bounding_box_core #(
    parameter int FRAC_BITS = tpbb_pkg::FRAC_BITS_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // kind[1:0], entry_index[5:2], matrix_value[37:6], point_x[69:38],
    // point_y[101:70], point_z[133:102], zero fill
    input  logic [135:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // low_x, low_y, low_z, high_x, high_y, high_z (32 bits each from bit 0)
    output logic [191:0]  m_tdata,
    // box_empty[0], w_was_zero[1], saturated[2]
    output logic [2:0]    m_tuser
);

    tpbb_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;

    assign in_item.kind         = tpbb_pkg::kind_t'(s_tdata[1:0]);
    assign in_item.entry_index  = s_tdata[5:2];
    assign in_item.matrix_value = s_tdata[37:6];
    assign in_item.point_x      = s_tdata[69:38];
    assign in_item.point_y      = s_tdata[101:70];
    assign in_item.point_z      = s_tdata[133:102];

    tpbb_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    tpbb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .low_x(m_tdata[31:0]), .low_y(m_tdata[63:32]), .low_z(m_tdata[95:64]),
        .high_x(m_tdata[127:96]), .high_y(m_tdata[159:128]), .high_z(m_tdata[191:160]),
        .box_empty(m_tuser[0]), .w_was_zero(m_tuser[1]), .saturated(m_tuser[2])
    );

endmodule

// ===== src/tpbb_front.sv =====
// Front end: accepts input beats and queues them as decoded items for the back end.
module tpbb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tpbb_pkg::item_t      in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tpbb_pkg::item_t      q_item
);

    localparam int D = tpbb_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    tpbb_pkg::item_t mem [D];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign in_ready = (cnt_reg != D[AW:0]);
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mem[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (in_valid && in_ready) begin
                wr_reg <= (wr_reg == AW'(D - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (q_valid && q_ready) begin
                rd_reg <= (rd_reg == AW'(D - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {AW'(0), (in_valid && in_ready)}
                               - {AW'(0), (q_valid && q_ready)};
        end
    end

endmodule

// ===== src/tpbb_back.sv =====
// Back end: matrix store, shared multiplier, serial divider and box accumulation.
module tpbb_back #(
    parameter int FRAC_BITS = tpbb_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  tpbb_pkg::item_t      q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          low_x,
    output logic [31:0]          low_y,
    output logic [31:0]          low_z,
    output logic [31:0]          high_x,
    output logic [31:0]          high_y,
    output logic [31:0]          high_z,
    output logic                 box_empty,
    output logic                 w_was_zero,
    output logic                 saturated
);

    localparam int SW = tpbb_pkg::SUM_W;
    localparam int DIVB = SW + FRAC_BITS;
    localparam int DCW = $clog2(DIVB + 1);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    tpbb_pkg::state_t state_reg, state_next;

    logic signed [31:0] mat_reg [16];
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic empty_reg, wz_reg, sat_reg;

    tpbb_pkg::item_t it_reg;
    logic [1:0] col_reg;
    logic [1:0] row_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] sum_reg [4];
    logic signed [31:0] t_reg [2];
    logic [1:0] ax_reg;

    logic [DIVB-1:0] dq_reg;
    logic [SW:0]     dr_reg;
    logic [SW-1:0]   dw_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic            dneg_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic signed [SW-1:0] fl;
    logic [1:0] mcol;
    logic [SW:0] dr_sh;
    logic [SW:0] dr_sub;
    logic [SW-1:0] nmag, wmag;
    logic signed [SW-1:0] nsel, wsum;
    logic [DIVB-1:0] qmag;
    logic signed [31:0] qval;
    logic qsat;

    // Column order: w first, then x, y, z.
    always_comb begin
        mcol = (col_reg == 2'd0) ? 2'd3 : col_reg - 2'd1;
        unique case (row_reg)
            2'd0:    mul_a = it_reg.point_x;
            2'd1:    mul_a = it_reg.point_y;
            default: mul_a = it_reg.point_z;
        endcase
        mul_b = mat_reg[{row_reg, mcol}];
        prod = mul_a * mul_b;
        fl = SW'(prod >>> FRAC_BITS);
        wsum = sum_reg[3];
        nsel = sum_reg[ax_reg];
        wmag = wsum[SW-1] ? SW'(-wsum) : SW'(wsum);
        nmag = nsel[SW-1] ? SW'(-nsel) : SW'(nsel);
        dr_sh = {dr_reg[SW-1:0], dq_reg[DIVB-1]};
        dr_sub = dr_sh - {1'b0, dw_reg};
        qmag = dq_reg;
        qsat = 1'b0;
        qval = '0;
        if (qmag[DIVB-1:32] != '0) begin
            qsat = 1'b1;
            qval = dneg_reg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (dneg_reg) begin
            if (qmag[30:0] != '0 && qmag[31]) begin
                qsat = 1'b1;
                qval = 32'sh80000000;
            end else begin
                qval = 32'(-qmag[31:0]);
            end
        end else if (qmag[31]) begin
            qsat = 1'b1;
            qval = 32'sh7fffffff;
        end else begin
            qval = 32'(qmag[31:0]);
        end
    end

    always_comb begin
        state_next = state_reg;
        q_ready = 1'b0;
        unique case (state_reg)
            tpbb_pkg::ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    state_next = (q_item.kind == tpbb_pkg::KIND_VERTEX)
                                 ? tpbb_pkg::ST_MAC : tpbb_pkg::ST_OUT;
                end
            end
            tpbb_pkg::ST_MAC: begin
                if (row_reg == 2'd2 && col_reg == 2'd3) begin
                    state_next = tpbb_pkg::ST_DIV;
                end else if (row_reg == 2'd2 && col_reg == 2'd0 &&
                             (acc_reg + fl) == '0) begin
                    state_next = tpbb_pkg::ST_OUT;
                end
            end
            tpbb_pkg::ST_DIV: begin
                if (dcnt_reg == '0 && ax_reg == 2'd2) begin
                    state_next = tpbb_pkg::ST_UPDATE;
                end
            end
            tpbb_pkg::ST_UPDATE: state_next = tpbb_pkg::ST_OUT;
            tpbb_pkg::ST_OUT: begin
                if (out_ready) begin
                    state_next = tpbb_pkg::ST_IDLE;
                end
            end
            default: state_next = tpbb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tpbb_pkg::ST_IDLE;
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= (i % 5 == 0) ? ONE : 32'sd0;
            end
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= 32'sh7fffffff;
                hi_reg[a] <= 32'sh80000000;
            end
            empty_reg <= 1'b1;
            wz_reg <= 1'b0;
            sat_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                tpbb_pkg::ST_IDLE: begin
                    if (q_valid) begin
                        it_reg <= q_item;
                        wz_reg <= 1'b0;
                        sat_reg <= 1'b0;
                        row_reg <= '0;
                        col_reg <= '0;
                        acc_reg <= SW'(mat_reg[12 + 3]);
                        unique case (q_item.kind)
                            tpbb_pkg::KIND_CLEAR: begin
                                for (int a = 0; a < 3; a++) begin
                                    lo_reg[a] <= 32'sh7fffffff;
                                    hi_reg[a] <= 32'sh80000000;
                                end
                                empty_reg <= 1'b1;
                            end
                            tpbb_pkg::KIND_MATRIX:
                                mat_reg[q_item.entry_index] <= q_item.matrix_value;
                            default: ;
                        endcase
                    end
                end
                tpbb_pkg::ST_MAC: begin
                    if (row_reg == 2'd2) begin
                        sum_reg[mcol] <= acc_reg + fl;
                        if (col_reg == 2'd0 && (acc_reg + fl) == '0) begin
                            wz_reg <= 1'b1;
                        end
                        row_reg <= '0;
                        col_reg <= col_reg + 2'd1;
                        acc_reg <= SW'(mat_reg[{2'd3, col_reg}]);
                        if (col_reg == 2'd3) begin
                            ax_reg <= '0;
                            dcnt_reg <= DCW'(DIVB);
                        end
                    end else begin
                        acc_reg <= acc_reg + fl;
                        row_reg <= row_reg + 2'd1;
                    end
                end
                tpbb_pkg::ST_DIV: begin
                    if (dcnt_reg == DCW'(DIVB)) begin
                        dq_reg <= {nmag, {FRAC_BITS{1'b0}}};
                        dr_reg <= '0;
                        dw_reg <= wmag;
                        dneg_reg <= nsel[SW-1] ^ wsum[SW-1];
                        dcnt_reg <= dcnt_reg - 1'b1;
                    end else begin
                        if (dr_sub[SW]) begin
                            dr_reg <= dr_sh;
                            dq_reg <= {dq_reg[DIVB-2:0], 1'b0};
                        end else begin
                            dr_reg <= dr_sub;
                            dq_reg <= {dq_reg[DIVB-2:0], 1'b1};
                        end
                        if (dcnt_reg == '0) begin
                            dcnt_reg <= DCW'(DIVB);
                            ax_reg <= ax_reg + 2'd1;
                        end else begin
                            dcnt_reg <= dcnt_reg - 1'b1;
                        end
                    end
                    if (dcnt_reg == DCW'(DIVB) && ax_reg != 2'd0) begin
                        t_reg[~ax_reg[0]] <= qval;
                        if (qsat) sat_reg <= 1'b1;
                    end
                end
                tpbb_pkg::ST_UPDATE: begin
                    for (int a = 0; a < 2; a++) begin
                        if (t_reg[a] < lo_reg[a]) lo_reg[a] <= t_reg[a];
                        if (t_reg[a] > hi_reg[a]) hi_reg[a] <= t_reg[a];
                    end
                    // The z quotient is still held in the divider.
                    if (qval < lo_reg[2]) lo_reg[2] <= qval;
                    if (qval > hi_reg[2]) hi_reg[2] <= qval;
                    if (qsat) sat_reg <= 1'b1;
                    empty_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign out_valid = (state_reg == tpbb_pkg::ST_OUT);
    assign low_x = lo_reg[0];
    assign low_y = lo_reg[1];
    assign low_z = lo_reg[2];
    assign high_x = hi_reg[0];
    assign high_y = hi_reg[1];
    assign high_z = hi_reg[2];
    assign box_empty = empty_reg;
    assign w_was_zero = wz_reg;
    assign saturated = sat_reg;

endmodule
